[rtl/core/eased_tween_interpolator_assert.svh]
// assertion macros used by the eased tween interpolator core
`ifndef EASED_TWEEN_INTERPOLATOR_ASSERT_SVH
`define EASED_TWEEN_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define ETI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ETI_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ETI_ASSERT(name, prop, msg)
`define ETI_ASSERT_RST(name, prop, msg)
`endif
`endif

[rtl/core/eti_pkg.sv]
// shared constants and codes for the eased tween interpolator
package eti_pkg;

    localparam int DEF_TIME_BITS     = 48;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_VALUE_BITS    = 32;

    localparam int DUR_BITS       = 24;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CURVE_BITS     = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_MODE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION_TICKS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_VALUE    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_VALUE      = 2'd3;

    localparam logic [CURVE_BITS-1:0] CURVE_LINEAR      = 3'd0;
    localparam logic [CURVE_BITS-1:0] CURVE_IN_QUAD     = 3'd1;
    localparam logic [CURVE_BITS-1:0] CURVE_OUT_QUAD    = 3'd2;
    localparam logic [CURVE_BITS-1:0] CURVE_INOUT_QUAD  = 3'd3;
    localparam logic [CURVE_BITS-1:0] CURVE_IN_CUBIC    = 3'd4;
    localparam logic [CURVE_BITS-1:0] CURVE_OUT_CUBIC   = 3'd5;
    localparam logic [CURVE_BITS-1:0] CURVE_INOUT_CUBIC = 3'd6;
    // spare code, behaves as linear
    localparam logic [CURVE_BITS-1:0] CURVE_SPARE       = 3'd7;

    localparam logic [CURVE_BITS-1:0] CURVE_RESET    = CURVE_INOUT_QUAD;
    localparam logic [DUR_BITS-1:0]   DURATION_RESET = 24'd250000;

endpackage

[rtl/core/eti_div.sv]
// bit-serial restoring divider producing the fractional offset
module eti_div #(
    parameter int NUM_BITS = eti_pkg::DUR_BITS,
    parameter int QUO_BITS = eti_pkg::DEF_FRACTION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [NUM_BITS-1:0] i_den,
    output logic                o_done,
    output logic [QUO_BITS-1:0] o_quo
);

    localparam int CW = $clog2(QUO_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_den;
    logic [QUO_BITS-1:0] r_quo;

    logic [NUM_BITS:0]   shifted;
    logic [NUM_BITS:0]   trial;
    logic                fits;

    // numerator stays below the divisor, so the remainder fits NUM_BITS
    assign shifted = {r_rem, 1'b0};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QUO_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
            r_quo <= {r_quo[QUO_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/core/eti_mul.sv]
// shared signed multiplier with registered operands and product
module eti_mul #(
    parameter int WIDTH = eti_pkg::DEF_VALUE_BITS + 2
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic signed [WIDTH-1:0]   i_a,
    input  logic signed [WIDTH-1:0]   i_b,
    output logic signed [2*WIDTH-1:0] o_p
);

    logic signed [WIDTH-1:0]   r_a;
    logic signed [WIDTH-1:0]   r_b;
    logic signed [2*WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_p <= r_a * r_b;
    end

    assign o_p = r_p;

endmodule

[rtl/core/eased_tween_interpolator.sv]
// Eased tween interpolator. A start beat (command 1) latches the frame stamp as the begin
// stamp, sets the end stamp to begin plus duration_ticks and answers with start_value. A tick
// beat (command 0) clamps its stamp between the stamps, forms an unsigned Q1.FRACTION_BITS
// offset, eases it with the selected curve and blends start_value to end_value, truncating
// toward zero. One beat is taken at a time: in_stall stays high until the result sits in
// the output register, which then holds it while the next beat is already being worked on.
// A tick whose time lies strictly inside the animation first runs the bit-serial offset
// divider at one quotient bit per cycle, then makes one pass through the one shared
// multiplier with a linear curve, two with a quadratic and three with a cubic curve;
// clamped times skip the divider. A result waits while the output register stays full.
module eased_tween_interpolator #(
    parameter int TIME_BITS     = eti_pkg::DEF_TIME_BITS,
    parameter int FRACTION_BITS = eti_pkg::DEF_FRACTION_BITS,
    parameter int VALUE_BITS    = eti_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [TIME_BITS-1:0]                i_frame_stamp,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [VALUE_BITS-1:0]        o_out_value,
    output logic [FRACTION_BITS:0]              o_eased_alpha,
    output logic                                o_updated,
    output logic                                o_running,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eti_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [eti_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    `include "eased_tween_interpolator_assert.svh"

    localparam int DW = eti_pkg::DUR_BITS;
    localparam int AW = FRACTION_BITS + 1;
    localparam int XW = FRACTION_BITS + 2;
    localparam int EW = FRACTION_BITS + 3;
    localparam int MW = (VALUE_BITS + 2 > EW) ? VALUE_BITS + 2 : EW;
    localparam int PW = 2 * MW;
    localparam int SW = VALUE_BITS + FRACTION_BITS + 2;

    localparam logic [AW-1:0] A_ONE  = AW'(64'd1 << FRACTION_BITS);
    localparam logic [XW-1:0] X_ONE  = XW'(64'd1 << FRACTION_BITS);
    localparam logic [XW-1:0] X_TWO  = XW'(64'd1 << (FRACTION_BITS + 1));
    localparam logic [EW-1:0] E_ONE  = EW'(64'd1 << FRACTION_BITS);
    localparam logic [EW-1:0] E_TWO  = EW'(64'd1 << (FRACTION_BITS + 1));
    localparam logic [SW-1:0] S_BIAS = SW'((64'd1 << FRACTION_BITS) - 64'd1);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_CLAMP  = 14'b00000000000010,
        S_OFFSET = 14'b00000000000100,
        S_DIV    = 14'b00000000001000,
        S_EASE   = 14'b00000000010000,
        S_MUL_A  = 14'b00000000100000,
        S_WAIT_A = 14'b00000001000000,
        S_MUL_B  = 14'b00000010000000,
        S_WAIT_B = 14'b00000100000000,
        S_ALPHA  = 14'b00001000000000,
        S_LERP   = 14'b00010000000000,
        S_WAIT_L = 14'b00100000000000,
        S_SUM    = 14'b01000000000000,
        S_ROUND  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [eti_pkg::CURVE_BITS-1:0] r_curve;
    logic [DW-1:0]                  r_dur;
    logic [eti_pkg::CFG_DATA_BITS-1:0] r_start;
    logic [eti_pkg::CFG_DATA_BITS-1:0] r_end_value;

    // animation state
    logic [TIME_BITS-1:0] r_begin;
    logic [TIME_BITS-1:0] r_end;
    logic [AW-1:0]        r_prev_off;
    logic                 r_prev_valid;

    // working registers
    logic                 r_cmd;
    logic [TIME_BITS-1:0] r_time;
    logic [AW-1:0]        r_off;
    logic [XW-1:0]        r_y;
    logic [XW-1:0]        r_b;
    logic                 r_low;
    logic [AW-1:0]        r_alpha;
    logic                 r_updated;
    logic                 r_running;
    logic signed [SW-1:0] r_sum;

    // output register
    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic [AW-1:0]                r_out_alpha;
    logic                         r_out_updated;
    logic                         r_out_running;

    logic                 in_take;
    logic                 out_free;
    logic                 out_load;

    logic                 div_start;
    logic [DW-1:0]        div_num;
    logic                 div_done;
    logic [FRACTION_BITS-1:0] div_quo;

    logic                 mul_load;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;

    logic [TIME_BITS-1:0] t_clamped;
    logic [XW-1:0]        x_ext;
    logic [XW-1:0]        p_ext;
    logic [XW-1:0]        q_ext;
    logic                 p_low;
    logic [XW-1:0]        y_next;
    logic [XW-1:0]        b_next;
    logic                 is_cubic;
    logic [EW-1:0]        q1;
    logic [EW-1:0]        q2;
    logic [EW-1:0]        alpha_wide;
    logic [VALUE_BITS-1:0] sv;
    logic [VALUE_BITS-1:0] ev;
    logic signed [VALUE_BITS:0] delta;
    logic [SW-1:0]        start_shift;
    logic [SW-1:0]        rounded;
    logic                 changed;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_ROUND) && out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    eti_div #(
        .NUM_BITS (DW),
        .QUO_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_dur),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    eti_mul #(
        .WIDTH (MW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_load (mul_load),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_p    (mul_p)
    );

    assign t_clamped = (r_time > r_end) ? r_end : ((r_time < r_begin) ? r_begin : r_time);

    assign div_start = (r_state == S_OFFSET) && (r_time != r_end) && (r_time != r_begin)
                       && (r_dur != '0);
    assign div_num   = DW'(r_time - r_begin);

    // ease operands: x, p = 2x, q = p - 1
    assign x_ext = {1'b0, r_off};
    assign p_ext = {r_off, 1'b0};
    assign q_ext = p_ext - X_ONE;
    assign p_low = p_ext < X_ONE;

    always_comb begin
        y_next = x_ext;
        b_next = x_ext;
        case (r_curve)
            eti_pkg::CURVE_OUT_QUAD: begin
                b_next = X_TWO - x_ext;
            end
            eti_pkg::CURVE_INOUT_QUAD: begin
                if (p_low) begin
                    y_next = p_ext;
                    b_next = p_ext;
                end else begin
                    y_next = q_ext;
                    b_next = X_TWO - q_ext;
                end
            end
            eti_pkg::CURVE_OUT_CUBIC: begin
                y_next = X_ONE - x_ext;
                b_next = X_ONE - x_ext;
            end
            eti_pkg::CURVE_INOUT_CUBIC: begin
                if (p_low) begin
                    y_next = p_ext;
                    b_next = p_ext;
                end else begin
                    y_next = X_TWO - p_ext;
                    b_next = X_TWO - p_ext;
                end
            end
            default: begin
                y_next = x_ext;
                b_next = x_ext;
            end
        endcase
    end

    assign is_cubic = (r_curve == eti_pkg::CURVE_IN_CUBIC)
                      || (r_curve == eti_pkg::CURVE_OUT_CUBIC)
                      || (r_curve == eti_pkg::CURVE_INOUT_CUBIC);

    // truncated fraction products
    assign q1 = mul_p[FRACTION_BITS +: EW];
    assign q2 = mul_p[FRACTION_BITS + 1 +: EW];

    always_comb begin
        case (r_curve)
            eti_pkg::CURVE_INOUT_QUAD:  alpha_wide = r_low ? q2 : ((E_ONE + q1) >> 1);
            eti_pkg::CURVE_OUT_CUBIC:   alpha_wide = E_ONE - q1;
            eti_pkg::CURVE_INOUT_CUBIC: alpha_wide = r_low ? (q1 >> 1) : ((E_TWO - q1) >> 1);
            default:                    alpha_wide = q1;
        endcase
    end

    assign sv    = r_start[VALUE_BITS-1:0];
    assign ev    = r_end_value[VALUE_BITS-1:0];
    assign delta = $signed({ev[VALUE_BITS-1], ev}) - $signed({sv[VALUE_BITS-1], sv});
    assign start_shift = {{2{sv[VALUE_BITS-1]}}, sv, {FRACTION_BITS{1'b0}}};

    always_comb begin
        mul_load = 1'b0;
        mul_a    = $signed({{(MW - XW){1'b0}}, r_y});
        mul_b    = $signed({{(MW - XW){1'b0}}, r_b});
        case (r_state)
            S_MUL_A: begin
                mul_load = 1'b1;
            end
            S_MUL_B: begin
                // cube: square times the base
                mul_load = is_cubic;
                mul_a    = $signed({{(MW - XW){1'b0}}, q1[XW-1:0]});
                mul_b    = $signed({{(MW - XW){1'b0}}, r_y});
            end
            S_LERP: begin
                mul_load = 1'b1;
                mul_a    = $signed({{(MW - VALUE_BITS - 1){delta[VALUE_BITS]}}, delta});
                mul_b    = $signed({{(MW - AW){1'b0}}, r_alpha});
            end
            default: begin
                mul_load = 1'b0;
            end
        endcase
    end

    assign changed = !r_prev_valid || (r_off != r_prev_off);

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign rounded = r_sum + (r_sum[SW-1] ? S_BIAS : '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_take) n_state = S_CLAMP;
            S_CLAMP:  n_state = r_cmd ? S_ROUND : S_OFFSET;
            S_OFFSET: n_state = div_start ? S_DIV : S_EASE;
            S_DIV:    if (div_done) n_state = S_EASE;
            S_EASE:   n_state = (r_curve == eti_pkg::CURVE_LINEAR
                                 || r_curve == eti_pkg::CURVE_SPARE)
                                ? S_LERP : S_MUL_A;
            S_MUL_A:  n_state = S_WAIT_A;
            S_WAIT_A: n_state = S_MUL_B;
            S_MUL_B:  n_state = is_cubic ? S_WAIT_B : S_ALPHA;
            S_WAIT_B: n_state = S_ALPHA;
            S_ALPHA:  n_state = S_LERP;
            S_LERP:   n_state = S_WAIT_L;
            S_WAIT_L: n_state = S_SUM;
            S_SUM:    n_state = S_ROUND;
            S_ROUND:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_curve      <= eti_pkg::CURVE_RESET;
            r_dur        <= eti_pkg::DURATION_RESET;
            r_start      <= '0;
            r_end_value  <= '0;
            r_begin      <= '0;
            r_end        <= '0;
            r_prev_off   <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    eti_pkg::REG_CURVE_MODE:
                        r_curve <= i_cfg_data[eti_pkg::CURVE_BITS-1:0];
                    eti_pkg::REG_DURATION_TICKS: r_dur       <= i_cfg_data[DW-1:0];
                    eti_pkg::REG_START_VALUE:    r_start     <= i_cfg_data;
                    eti_pkg::REG_END_VALUE:      r_end_value <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_CLAMP && r_cmd) begin
                r_begin      <= r_time;
                r_end        <= r_time + {{(TIME_BITS - DW){1'b0}}, r_dur};
                r_prev_off   <= '0;
                r_prev_valid <= 1'b0;
            end
            if (r_state == S_EASE && changed) begin
                r_prev_off   <= r_off;
                r_prev_valid <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= i_command;
            r_time <= i_frame_stamp;
        end
        case (r_state)
            S_CLAMP: begin
                if (r_cmd) begin
                    r_sum     <= $signed(start_shift);
                    r_alpha   <= '0;
                    r_updated <= 1'b0;
                    r_running <= 1'b1;
                end else begin
                    r_time <= t_clamped;
                end
            end
            S_OFFSET: begin
                if (r_time == r_end || (r_time != r_begin && r_dur == '0)) begin
                    r_off <= A_ONE;
                end else begin
                    r_off <= '0;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_off <= {1'b0, div_quo};
                end
            end
            S_EASE: begin
                r_y       <= y_next;
                r_b       <= b_next;
                r_low     <= p_low;
                r_alpha   <= r_off;
                r_updated <= changed;
                r_running <= (r_off < A_ONE);
            end
            S_ALPHA: begin
                r_alpha <= alpha_wide[AW-1:0];
            end
            S_SUM: begin
                r_sum <= $signed(start_shift) + $signed(mul_p[SW-1:0]);
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_value   <= $signed(rounded[FRACTION_BITS +: VALUE_BITS]);
            r_out_alpha   <= r_alpha;
            r_out_updated <= r_updated;
            r_out_running <= r_running;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_eased_alpha = r_out_alpha;
    assign o_updated     = r_out_updated;
    assign o_running     = r_out_running;

    `ETI_ASSERT(a_alpha_bound, o_out_valid |-> (o_eased_alpha <= A_ONE), "eased alpha above one")
    `ETI_ASSERT(a_done_alpha_one, (o_out_valid && !o_running) |-> (o_eased_alpha == A_ONE), "finished tween without full alpha")
    `ETI_ASSERT(a_div_done_state, div_done |-> (r_state == S_DIV), "divider finished outside divide wait")
    `ETI_ASSERT(a_prev_mark_set, (r_state == S_EASE) |=> r_prev_valid, "offset mark not recorded after a tick")
    `ETI_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result pending after reset")

endmodule

[bench/tb.sv]
// self-checking testbench for the eased tween interpolator with a cycle-free predictor
`timescale 1ns / 1ps

module tb;

    localparam int TB  = eti_pkg::DEF_TIME_BITS;
    localparam int FB  = eti_pkg::DEF_FRACTION_BITS;
    localparam int VB  = eti_pkg::DEF_VALUE_BITS;
    localparam int CIB = eti_pkg::CFG_INDEX_BITS;
    localparam int CDB = eti_pkg::CFG_DATA_BITS;
    localparam int DB  = eti_pkg::DUR_BITS;
    localparam int CB  = eti_pkg::CURVE_BITS;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [63:0]   UNITY     = 64'd1 << FB;
    localparam logic [TB-1:0] TIME_TOP  = '1;
    localparam int SEGMENTS             = 12;
    localparam int SEGMENT_BEATS        = 42;
    localparam int DRAIN_CYCLES         = 40;

    typedef struct packed {
        logic          command;
        logic [TB-1:0] stamp;
    } t_frame_beat;

    typedef struct packed {
        logic signed [VB-1:0] value;
        logic [FB:0]          alpha;
        logic                 updated;
        logic                 running;
    } t_tween_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [TB-1:0]         i_frame_stamp;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [VB-1:0]  o_out_value;
    logic [FB:0]           o_eased_alpha;
    logic                  o_updated;
    logic                  o_running;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CIB-1:0]        i_cfg_index;
    logic [CDB-1:0]        i_cfg_data;

    eased_tween_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_frame_stamp (i_frame_stamp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_value   (o_out_value),
        .o_eased_alpha (o_eased_alpha),
        .o_updated     (o_updated),
        .o_running     (o_running),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers and the animation state
    logic [CB-1:0]         mode;
    logic [DB-1:0]         span;
    logic signed [VB-1:0]  blend_from;
    logic signed [VB-1:0]  blend_to;
    logic [TB-1:0]         anim_begin;
    logic [TB-1:0]         anim_end;
    logic [FB:0]           prior_offset;
    logic                  prior_offset_known;

    t_frame_beat   pending_beats[$];
    t_tween_result projected_tweens[$];
    t_frame_beat   next_beat;
    t_tween_result arrived;
    bit            beat_taken;
    int            send_gap_pct;
    int            recv_stall_pct;
    int            queued_total;
    int            failures;

    function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
        return (a * b) >> FB;
    endfunction

    function automatic logic [63:0] fx_cubed(logic [63:0] a);
        return fx_product(fx_product(a, a), a);
    endfunction

    function automatic logic [63:0] eased(logic [63:0] x);
        logic [63:0] p;
        logic [63:0] q;
        p = x << 1;
        q = p - UNITY;
        case (mode)
            eti_pkg::CURVE_IN_QUAD:    return fx_product(x, x);
            eti_pkg::CURVE_OUT_QUAD:   return fx_product(x, 2 * UNITY - x);
            eti_pkg::CURVE_INOUT_QUAD: begin
                if (p < UNITY)
                    return (p * p) >> (FB + 1);
                return (UNITY + fx_product(q, 2 * UNITY - q)) >> 1;
            end
            eti_pkg::CURVE_IN_CUBIC:   return fx_cubed(x);
            eti_pkg::CURVE_OUT_CUBIC:  return UNITY - fx_cubed(UNITY - x);
            eti_pkg::CURVE_INOUT_CUBIC: begin
                if (p < UNITY)
                    return fx_cubed(p) >> 1;
                return (2 * UNITY - fx_cubed(2 * UNITY - p)) >> 1;
            end
            default:                   return x;
        endcase
    endfunction

    // exact blend, signed division truncates toward zero
    function automatic logic [VB-1:0] blended(logic [63:0] alpha);
        longint a;
        longint b;
        longint sum;
        a = longint'(blend_from);
        b = longint'(blend_to);
        sum = a * longint'(UNITY) + (b - a) * longint'(alpha);
        return VB'(sum / longint'(UNITY));
    endfunction

    // end is tested before begin, so a zero duration lands on one
    function automatic logic [63:0] progress_at(logic [TB-1:0] t);
        logic [TB-1:0] c;
        c = t;
        if (c > anim_end)
            c = anim_end;
        else if (c < anim_begin)
            c = anim_begin;
        if (c == anim_end)
            return UNITY;
        if (c == anim_begin)
            return 64'd0;
        if (span == 0)
            return UNITY;
        return (64'(c - anim_begin) << FB) / 64'(span);
    endfunction

    task automatic project_tween(logic cmd, logic [TB-1:0] t);
        t_tween_result r;
        logic [63:0]   off;
        logic [63:0]   alpha;
        if (cmd == CMD_START) begin
            anim_begin = t;
            anim_end = t + TB'(span);
            prior_offset_known = 1'b0;
            prior_offset = '0;
            r.value = blend_from;
            r.alpha = '0;
            r.updated = 1'b0;
            r.running = 1'b1;
        end else begin
            off = progress_at(t);
            alpha = eased(off);
            r.updated = !prior_offset_known || off != 64'(prior_offset);
            if (r.updated) begin
                prior_offset = off[FB:0];
                prior_offset_known = 1'b1;
            end
            r.value = blended(alpha);
            r.alpha = alpha[FB:0];
            r.running = off < UNITY;
        end
        projected_tweens.push_back(r);
    endtask

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic queue_beat(logic cmd, logic [TB-1:0] t);
        t_frame_beat b;
        b.command = cmd;
        b.stamp = t;
        pending_beats.push_back(b);
        queued_total++;
    endtask

    // a start followed by ticks mostly inside the animation window
    task automatic queue_animation(int ticks);
        logic [TB-1:0] base;
        logic [TB-1:0] t;
        logic [TB-1:0] prev;
        int            r;
        base = TB'({$urandom(), $urandom()});
        if ($urandom_range(0, 3) == 0)
            base = TIME_TOP - TB'($urandom_range(0, span));
        queue_beat(CMD_START, base);
        prev = base;
        for (int i = 0; i < ticks; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                t = prev;
            else if (r < 18)
                t = base - TB'($urandom_range(1, 64));
            else if (r < 26)
                t = base + TB'(span) + TB'($urandom_range(0, 64));
            else if (r < 30)
                t = TB'({$urandom(), $urandom()});
            else
                t = base + TB'($urandom_range(0, span));
            queue_beat(CMD_TICK, t);
            prev = t;
        end
    endtask

    task automatic write_reg(logic [CIB-1:0] idx, logic [CDB-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            eti_pkg::REG_CURVE_MODE:     mode = data[CB-1:0];
            eti_pkg::REG_DURATION_TICKS: span = data[DB-1:0];
            eti_pkg::REG_START_VALUE:    blend_from = data[VB-1:0];
            eti_pkg::REG_END_VALUE:      blend_to = data[VB-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [CB-1:0] c, logic [DB-1:0] d,
                                logic [VB-1:0] s, logic [VB-1:0] e);
        write_reg(eti_pkg::REG_CURVE_MODE, CDB'(c));
        write_reg(eti_pkg::REG_DURATION_TICKS, CDB'(d));
        write_reg(eti_pkg::REG_START_VALUE, CDB'(s));
        write_reg(eti_pkg::REG_END_VALUE, CDB'(e));
    endtask

    // nothing queued, nothing in flight, then a margin for the block itself
    task automatic settle();
        while (pending_beats.size() != 0 || i_in_valid || projected_tweens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [VB-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return {1'b1, {(VB-1){1'b0}}};
            1:       return {1'b0, {(VB-1){1'b1}}};
            2:       return '0;
            default: return VB'($urandom());
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            // a stalled beat stays put until it is taken
            if (!i_in_valid || beat_taken) begin
                beat_taken = 1'b0;
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    next_beat = pending_beats.pop_front();
                    i_command <= next_beat.command;
                    i_frame_stamp <= next_beat.stamp;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                project_tween(i_command, i_frame_stamp);
                beat_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (projected_tweens.size() == 0) begin
                    $error("result beat with nothing outstanding: value %0d",
                           $signed(o_out_value));
                    failures++;
                end else begin
                    arrived = projected_tweens.pop_front();
                    check_field("out_value", $signed(arrived.value), $signed(o_out_value));
                    check_field("eased_alpha", arrived.alpha, o_eased_alpha);
                    check_field("updated", arrived.updated, o_updated);
                    check_field("running", arrived.running, o_running);
                end
            end
        end
    end

    initial begin
        int seg;
        int goal;
        logic [DB-1:0] d;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = CMD_TICK;
        i_frame_stamp = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = eti_pkg::REG_CURVE_MODE;
        i_cfg_data = '0;
        beat_taken = 1'b0;
        failures = 0;
        queued_total = 0;
        send_gap_pct = 33;
        recv_stall_pct = 69;
        mode = eti_pkg::CURVE_RESET;
        span = eti_pkg::DURATION_RESET;
        blend_from = '0;
        blend_to = '0;
        anim_begin = '0;
        anim_end = '0;
        prior_offset = '0;
        prior_offset_known = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ticks before any start: both stamps zero, then a repeated offset
        queue_beat(CMD_TICK, '0);
        queue_beat(CMD_TICK, TIME_TOP);
        settle();

        // spare curve code, full value swing, clamps either side
        program_regs(eti_pkg::CURVE_SPARE, 24'd1000, {1'b1, {(VB-1){1'b0}}},
                     {1'b0, {(VB-1){1'b1}}});
        queue_beat(CMD_START, 48'h1000);
        queue_beat(CMD_TICK, 48'h1000);
        queue_beat(CMD_TICK, 48'h1001);
        queue_beat(CMD_TICK, 48'h1000 + 48'd500);
        queue_beat(CMD_TICK, 48'h1000 + 48'd500);
        queue_beat(CMD_TICK, 48'h1000 + 48'd999);
        queue_beat(CMD_TICK, 48'h1000 + 48'd1000);
        queue_beat(CMD_TICK, TIME_TOP);
        queue_beat(CMD_TICK, '0);
        settle();

        // zero duration
        program_regs(eti_pkg::CURVE_INOUT_CUBIC, '0, {1'b0, {(VB-1){1'b1}}},
                     {1'b1, {(VB-1){1'b0}}});
        queue_beat(CMD_START, 48'h5555_5555_5555);
        queue_beat(CMD_TICK, 48'h5555_5555_5555);
        queue_beat(CMD_TICK, 48'hAAAA_AAAA_AAAA);
        settle();

        // longest duration with the end stamp wrapping past the top
        program_regs(eti_pkg::CURVE_OUT_CUBIC, '1, pick_level(), pick_level());
        queue_beat(CMD_START, TIME_TOP - 48'hF);
        queue_beat(CMD_TICK, TIME_TOP - 48'h7);
        queue_beat(CMD_TICK, 48'h4);
        queue_beat(CMD_TICK, TIME_TOP - 48'hF);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            if (seg == 4) begin
                send_gap_pct = 69;
                recv_stall_pct = 33;
            end
            if (seg == 8) begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = 24'd1;
                2:       d = '1;
                3, 4, 5: d = DB'($urandom_range(2, 300));
                default: d = DB'($urandom_range(2, 24'hFFFFFF));
            endcase
            // segment index walks through every curve code
            program_regs(CB'(seg), d, pick_level(), pick_level());
            goal = queued_total + SEGMENT_BEATS;
            while (queued_total < goal) begin
                if ($urandom_range(0, 99) < 85)
                    queue_animation($urandom_range(2, 10));
                else
                    queue_beat(1'($urandom()), TB'({$urandom(), $urandom()}));
            end
        end

        settle();
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/eti_pkg.sv
rtl/core/eti_div.sv
rtl/core/eti_mul.sv
rtl/core/eased_tween_interpolator.sv
bench/tb.sv
